// ----- rtl/stable_sorted_priority_queue_core_defines.svh -----
// Assertion macros shared by the queue RTL files.
`ifndef STABLE_SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define SSPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a condition leads to a consequence in the next cycle.
`define SSPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SSPQ_ASSERT(lbl, prop, msg)
`define SSPQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/sspq_pkg.sv -----
// Types, constants and helpers of the stable sorted priority queue.
package sspq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int FUNC_W      = 3;
  localparam int DATA_W      = 32;
  localparam int PRIO_W      = 16;
  localparam int POS_W       = 4;
  localparam int STATUS_W    = 2;
  localparam int OCNT_W      = 5;

  // Command codes on the request channel
  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT    = 3'd0,
    FN_DEL_PRIO  = 3'd1,
    FN_DEL_FIRST = 3'd2,
    FN_DEL_MATCH = 3'd3,
    FN_CLEAR     = 3'd4,
    FN_READ      = 3'd5
  } func_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  // Per-cycle action of the cell row
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_WAIT
  } state_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    cell_op_t                   op;
    logic                       match_data;
    logic signed [DATA_W-1:0]   key_data;
    logic signed [PRIO_W-1:0]   key_prio;
  } cell_cmd_t;

  // Fold an internal count onto the 5-bit result field (wraps above 31)
  function automatic logic [OCNT_W-1:0] to_out_cnt(input logic [CNT_W-1:0] c);
    logic [CNT_W+OCNT_W-1:0] t;
    t = {{OCNT_W{1'b0}}, c};
    return t[OCNT_W-1:0];
  endfunction

endpackage

// ----- rtl/sspq_ifs.sv -----
// Request and response channel interfaces of the priority queue.
interface sspq_req_if import sspq_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [DATA_W-1:0] data_value;
  logic signed [PRIO_W-1:0] prio;
  logic [POS_W-1:0]         position;

  modport source (output valid, func, data_value, prio, position, input ready);
  modport sink (input valid, func, data_value, prio, position, output ready);
endinterface

interface sspq_rsp_if import sspq_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [OCNT_W-1:0]        removed_count;
  logic [OCNT_W-1:0]        entry_count;
  logic signed [DATA_W-1:0] read_data;
  logic signed [PRIO_W-1:0] read_prio;

  modport source (output valid, status, removed_count, entry_count, read_data, read_prio,
                  input ready);
  modport sink (input valid, status, removed_count, entry_count, read_data, read_prio,
                output ready);
endinterface

// ----- rtl/sspq_cell.sv -----
// One slot of the sorted cell row: holds a data/priority pair and trades with neighbors.
module sspq_cell import sspq_pkg::*; (
  input  logic                     clk,
  input  cell_cmd_t                cmd,
  input  logic                     occ,
  input  logic signed [DATA_W-1:0] left_data,
  input  logic signed [PRIO_W-1:0] left_prio,
  input  logic                     left_ge,
  input  logic                     left_seen,
  input  logic signed [DATA_W-1:0] right_data,
  input  logic signed [PRIO_W-1:0] right_prio,
  output logic signed [DATA_W-1:0] data,
  output logic signed [PRIO_W-1:0] prio,
  output logic                     ge,
  output logic                     seen
);

  logic hit;

  // Slot is free or holds a later priority: the new entry goes at or before it
  assign ge   = !occ || (prio > cmd.key_prio);
  // Slot matches the delete key
  assign hit  = occ && (prio == cmd.key_prio) && (!cmd.match_data || data == cmd.key_data);
  // A match at or before this slot: this slot and all after it shift left
  assign seen = left_seen || hit;

  // Insert: load key at the boundary, shift right after it. Remove: pull from the right.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_INSERT: begin
        if (ge) begin
          if (!left_ge) begin
            data <= cmd.key_data;
            prio <= cmd.key_prio;
          end else begin
            data <= left_data;
            prio <= left_prio;
          end
        end
      end
      OP_REMOVE: begin
        if (seen) begin
          data <= right_data;
          prio <= right_prio;
        end
      end
      OP_HOLD: begin
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/sspq_ctrl.sv -----
// Command sequencer, entry count and result register of the priority queue.
`include "stable_sorted_priority_queue_core_defines.svh"
module sspq_ctrl import sspq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  sspq_req_if.sink                 req,
  sspq_rsp_if.source               rsp,
  input  logic                     any_hit,
  input  logic signed [DATA_W-1:0] rd_data,
  input  logic signed [PRIO_W-1:0] rd_prio,
  output cell_cmd_t                cmd,
  output logic [CNT_W-1:0]         count,
  output logic [POS_W-1:0]         rd_pos
);

  state_t                   state, state_next;
  logic [CNT_W-1:0]         count_next;
  logic [CNT_W-1:0]         rem_cnt, rem_cnt_next;
  logic [FUNC_W-1:0]        func_q;
  logic signed [DATA_W-1:0] data_q;
  logic signed [PRIO_W-1:0] prio_q;

  logic                     out_valid;
  logic [STATUS_W-1:0]      out_status;
  logic [OCNT_W-1:0]        out_removed;
  logic [OCNT_W-1:0]        out_count;
  logic signed [DATA_W-1:0] out_data;
  logic signed [PRIO_W-1:0] out_prio;

  logic [STATUS_W-1:0]      pend_status;
  logic [OCNT_W-1:0]        pend_removed;
  logic [OCNT_W-1:0]        pend_count;
  logic signed [DATA_W-1:0] pend_data;
  logic signed [PRIO_W-1:0] pend_prio;

  status_t                  res_status;
  logic [CNT_W-1:0]         res_removed;
  logic signed [DATA_W-1:0] res_data;
  logic signed [PRIO_W-1:0] res_prio;
  logic                     done;
  logic                     slot_free;
  logic                     load_out;
  logic                     from_pend;
  logic                     load_pend;
  logic                     empty_start;
  logic                     past_end;
  logic                     is_full;

  assign req.ready         = (state == S_IDLE);
  assign slot_free         = !out_valid || rsp.ready;
  assign empty_start       = (count == '0) && (rem_cnt == '0);
  assign past_end          = (CNT_W + POS_W)'(rd_pos) >= (CNT_W + POS_W)'(count);
  assign is_full           = (count == CNT_W'(QUEUE_DEPTH));

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.removed_count = out_removed;
  assign rsp.entry_count   = out_count;
  assign rsp.read_data     = out_data;
  assign rsp.read_prio     = out_prio;

  // Next state, cell command and result of the current step
  always_comb begin
    state_next     = state;
    count_next     = count;
    rem_cnt_next   = rem_cnt;
    cmd.op         = OP_HOLD;
    cmd.match_data = (func_t'(func_q) == FN_DEL_MATCH);
    cmd.key_data   = data_q;
    cmd.key_prio   = prio_q;
    res_status     = ST_OK;
    res_removed    = '0;
    res_data       = '0;
    res_prio       = '0;
    done           = 1'b0;
    load_out       = 1'b0;
    from_pend      = 1'b0;
    load_pend      = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          rem_cnt_next = '0;
          state_next   = S_RUN;
        end
      end
      S_RUN: begin
        done = 1'b1;
        unique case (func_t'(func_q))
          FN_INSERT: begin
            if (is_full) begin
              res_status = ST_FULL;
            end else begin
              cmd.op     = OP_INSERT;
              count_next = count + CNT_W'(1);
            end
          end
          FN_DEL_PRIO, FN_DEL_FIRST, FN_DEL_MATCH: begin
            if (empty_start) begin
              res_status = ST_EMPTY;
            end else begin
              // Remove the first remaining match this cycle
              if (any_hit) begin
                cmd.op     = OP_REMOVE;
                count_next = count - CNT_W'(1);
              end
              res_removed  = rem_cnt + CNT_W'(any_hit);
              rem_cnt_next = res_removed;
              done         = !any_hit || (func_t'(func_q) == FN_DEL_FIRST);
              res_status   = (res_removed == '0) ? ST_NOTFOUND : ST_OK;
            end
          end
          FN_CLEAR: begin
            if (count == '0) begin
              res_status = ST_EMPTY;
            end else begin
              res_removed = count;
              count_next  = '0;
            end
          end
          FN_READ: begin
            priority if (count == '0) begin
              res_status = ST_EMPTY;
            end else if (past_end) begin
              res_status = ST_NOTFOUND;
            end else begin
              res_data = rd_data;
              res_prio = rd_prio;
            end
          end
          default: begin
          end
        endcase
        if (done) begin
          if (slot_free) begin
            load_out   = 1'b1;
            state_next = S_IDLE;
          end else begin
            load_pend  = 1'b1;
            state_next = S_WAIT;
          end
        end
      end
      S_WAIT: begin
        if (slot_free) begin
          load_out   = 1'b1;
          from_pend  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rem_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      rem_cnt <= rem_cnt_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Capture the command beat
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      func_q <= req.func;
      data_q <= req.data_value;
      prio_q <= req.prio;
      rd_pos <= req.position;
    end
  end

  // Hold a finished result while the output register is still occupied
  always_ff @(posedge clk) begin
    if (load_pend) begin
      pend_status  <= res_status;
      pend_removed <= to_out_cnt(res_removed);
      pend_count   <= to_out_cnt(count_next);
      pend_data    <= res_data;
      pend_prio    <= res_prio;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      if (from_pend) begin
        out_status  <= pend_status;
        out_removed <= pend_removed;
        out_count   <= pend_count;
        out_data    <= pend_data;
        out_prio    <= pend_prio;
      end else begin
        out_status  <= res_status;
        out_removed <= to_out_cnt(res_removed);
        out_count   <= to_out_cnt(count_next);
        out_data    <= res_data;
        out_prio    <= res_prio;
      end
    end
  end

  `SSPQ_ASSERT(a_count_bound, count <= CNT_W'(QUEUE_DEPTH), "entry count above depth")
  `SSPQ_ASSERT(a_no_insert_full, (cmd.op == OP_INSERT) |-> !is_full, "insert into full row")
  `SSPQ_ASSERT_NEXT(a_accept_runs, req.valid && req.ready, state == S_RUN, "no step after beat")
  `SSPQ_ASSERT_NEXT(a_count_quiet, state != S_RUN, count == $past(count), "count moved idle")
  `SSPQ_ASSERT_NEXT(a_remove_one, cmd.op == OP_REMOVE, count < $past(count), "count not dropped")

endmodule

// ----- rtl/stable_sorted_priority_queue_core.sv -----
// Top level of the stable sorted priority queue: controller plus a row of sorted cells.
//
//   channel  direction  payload                                          handshake
//   req      in         func, data_value, prio, position                 valid/ready
//   rsp      out        status, removed_count, entry_count,              valid/ready
//                       read_data, read_prio
//
// Insert, clear, read, delete-first and unused codes complete in a single pass of the run state.
// Delete-all and delete-match repeat the run state while matches remain: the cell row
// drops one matching entry per cycle and closes with a scan that finds no match.
// A result waits in a holding register while the output register is occupied; the next
// command beat is taken once the previous result has reached the output register.
// Reset clears the entry count and the handshake state; entry contents are not cleared.
`include "stable_sorted_priority_queue_core_defines.svh"
module stable_sorted_priority_queue_core import sspq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  sspq_req_if.sink   req,
  sspq_rsp_if.source rsp
);

  cell_cmd_t                cmd;
  logic [CNT_W-1:0]         count;
  logic [POS_W-1:0]         rd_pos;
  logic signed [DATA_W-1:0] rd_data;
  logic signed [PRIO_W-1:0] rd_prio;

  logic signed [DATA_W-1:0] cell_data [QUEUE_DEPTH];
  logic signed [PRIO_W-1:0] cell_prio [QUEUE_DEPTH];
  logic                     ge_chain  [QUEUE_DEPTH+1];
  logic                     seen_chain[QUEUE_DEPTH+1];

  assign ge_chain[0]   = 1'b0;
  assign seen_chain[0] = 1'b0;

  sspq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .any_hit (seen_chain[QUEUE_DEPTH]),
    .rd_data (rd_data),
    .rd_prio (rd_prio),
    .cmd     (cmd),
    .count   (count),
    .rd_pos  (rd_pos)
  );

  // Build the cell row, each cell wired to its neighbors
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] l_data;
    logic signed [PRIO_W-1:0] l_prio;
    logic signed [DATA_W-1:0] r_data;
    logic signed [PRIO_W-1:0] r_prio;
    logic                     occ;

    assign occ = (CNT_W + 1)'(i) < (CNT_W + 1)'(count);

    if (i == 0) begin : g_head
      assign l_data = '0;
      assign l_prio = '0;
    end else begin : g_left
      assign l_data = cell_data[i-1];
      assign l_prio = cell_prio[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_data = '0;
      assign r_prio = '0;
    end else begin : g_right
      assign r_data = cell_data[i+1];
      assign r_prio = cell_prio[i+1];
    end

    sspq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .occ        (occ),
      .left_data  (l_data),
      .left_prio  (l_prio),
      .left_ge    (ge_chain[i]),
      .left_seen  (seen_chain[i]),
      .right_data (r_data),
      .right_prio (r_prio),
      .data       (cell_data[i]),
      .prio       (cell_prio[i]),
      .ge         (ge_chain[i+1]),
      .seen       (seen_chain[i+1])
    );
  end

  // Select the cell at the read position
  always_comb begin
    rd_data = '0;
    rd_prio = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (int'(rd_pos) == i) begin
        rd_data = cell_data[i];
        rd_prio = cell_prio[i];
      end
    end
  end

  `SSPQ_ASSERT(a_ready_no_cmd, req.ready |-> (cmd.op == OP_HOLD), "row busy while ready")
  `SSPQ_ASSERT_NEXT(a_insert_grows, cmd.op == OP_INSERT, count > $past(count), "insert kept count")
  `SSPQ_ASSERT(a_remove_hit, (cmd.op == OP_REMOVE) |-> seen_chain[QUEUE_DEPTH], "no match")

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for the stable sorted priority queue core.
module tb_top;
  import sspq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Func codes the block ignores
  localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd7;

  localparam int RANDOM_ITEMS = 1800;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] data_value;
    logic signed [PRIO_W-1:0] prio;
    logic [POS_W-1:0]         position;
  } command_t;

  typedef struct packed {
    status_t                  status;
    logic [OCNT_W-1:0]        removed_count;
    logic [OCNT_W-1:0]        entry_count;
    logic signed [DATA_W-1:0] read_data;
    logic signed [PRIO_W-1:0] read_prio;
  } outcome_t;

  // Shadow copy of the sorted queue plus the outcomes still owed by the block
  class queue_shadow;
    logic signed [DATA_W-1:0] slot_data [QUEUE_DEPTH];
    logic signed [PRIO_W-1:0] slot_prio [QUEUE_DEPTH];
    int unsigned              depth_used;
    outcome_t                 owed_outcomes [$];
    int                       errors;
    int                       taken;
    int                       matched;
    int                       full_drops;
    int                       misses;
    int                       empties;
    int unsigned              peak_removed;

    function new();
      depth_used = 0;
      errors = 0;
      taken = 0;
      matched = 0;
      full_drops = 0;
      misses = 0;
      empties = 0;
      peak_removed = 0;
    endfunction

    // Apply one accepted command to the shadow queue and queue its outcome
    function void take_command(command_t c);
      outcome_t    o;
      int unsigned at;
      int unsigned rd;
      int unsigned wr;
      int unsigned removed;
      logic        hit;
      o.status = ST_OK;
      o.read_data = '0;
      o.read_prio = '0;
      removed = 0;
      case (c.func)
        FN_INSERT: begin
          if (depth_used >= QUEUE_DEPTH) begin
            o.status = ST_FULL;
          end else begin
            // land after the last entry of equal priority
            at = 0;
            while (at < depth_used && slot_prio[at] <= c.prio) at++;
            for (rd = depth_used; rd > at; rd--) begin
              slot_data[rd] = slot_data[rd-1];
              slot_prio[rd] = slot_prio[rd-1];
            end
            slot_data[at] = c.data_value;
            slot_prio[at] = c.prio;
            depth_used++;
          end
        end
        FN_DEL_PRIO, FN_DEL_FIRST, FN_DEL_MATCH: begin
          if (depth_used == 0) begin
            o.status = ST_EMPTY;
          end else begin
            // compact the survivors toward the head
            wr = 0;
            for (rd = 0; rd < depth_used; rd++) begin
              hit = (slot_prio[rd] == c.prio);
              if (c.func == FN_DEL_MATCH) hit = hit && (slot_data[rd] == c.data_value);
              if (c.func == FN_DEL_FIRST && removed > 0) hit = 1'b0;
              if (hit) begin
                removed++;
              end else begin
                slot_data[wr] = slot_data[rd];
                slot_prio[wr] = slot_prio[rd];
                wr++;
              end
            end
            depth_used = wr;
            if (removed == 0) o.status = ST_NOTFOUND;
          end
        end
        FN_CLEAR: begin
          if (depth_used == 0) begin
            o.status = ST_EMPTY;
          end else begin
            removed = depth_used;
            depth_used = 0;
          end
        end
        FN_READ: begin
          if (depth_used == 0) begin
            o.status = ST_EMPTY;
          end else if (c.position >= depth_used) begin
            o.status = ST_NOTFOUND;
          end else begin
            o.read_data = slot_data[c.position];
            o.read_prio = slot_prio[c.position];
          end
        end
        default: ;
      endcase
      o.removed_count = removed[OCNT_W-1:0];
      o.entry_count = depth_used[OCNT_W-1:0];
      if (o.status == ST_FULL) full_drops++;
      if (o.status == ST_NOTFOUND) misses++;
      if (o.status == ST_EMPTY) empties++;
      if (removed > peak_removed) peak_removed = removed;
      taken++;
      owed_outcomes.push_back(o);
    endfunction

    // Compare one delivered outcome with the oldest one owed
    function void match_result(outcome_t got);
      outcome_t want;
      if (owed_outcomes.size() == 0) begin
        $error("result beat with no command outstanding");
        errors++;
        return;
      end
      want = owed_outcomes.pop_front();
      matched++;
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.removed_count !== want.removed_count) begin
        $error("removed_count: expected %0d, got %0d", want.removed_count, got.removed_count);
        errors++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
        errors++;
      end
      if (got.read_data !== want.read_data) begin
        $error("read_data: expected %0d, got %0d", want.read_data, got.read_data);
        errors++;
      end
      if (got.read_prio !== want.read_prio) begin
        $error("read_prio: expected %0d, got %0d", want.read_prio, got.read_prio);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic calm;
  int   hold_off_asks;

  sspq_req_if req ();
  sspq_rsp_if rsp ();

  queue_shadow shadow = new();

  stable_sorted_priority_queue_core dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Free-running clock, 2 ns period
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly short idle gaps, now and then a long one
  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic command_t command(logic [FUNC_W-1:0] f, logic signed [DATA_W-1:0] d,
                                       logic signed [PRIO_W-1:0] p, logic [POS_W-1:0] pos);
    command_t c;
    c.func = f;
    c.data_value = d;
    c.prio = p;
    c.position = pos;
    return c;
  endfunction

  // Favor priorities already queued so deletes find matches
  function automatic logic signed [PRIO_W-1:0] pick_prio();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40 && shadow.depth_used > 0)
      return shadow.slot_prio[$urandom_range(0, shadow.depth_used - 1)];
    if (r < 80) begin
      case ($urandom_range(0, 5))
        0: return 16'sh8000;
        1: return -16'sd1;
        2: return 16'sd0;
        3: return 16'sd1;
        4: return 16'sd7;
        default: return 16'sh7fff;
      endcase
    end
    return PRIO_W'($urandom);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_data();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25 && shadow.depth_used > 0)
      return shadow.slot_data[$urandom_range(0, shadow.depth_used - 1)];
    if (r < 50) begin
      case ($urandom_range(0, 4))
        0: return 32'sd0;
        1: return -32'sd1;
        2: return 32'sd1;
        3: return 32'sh7fffffff;
        default: return 32'sh80000000;
      endcase
    end
    return $urandom;
  endfunction

  function automatic command_t random_command();
    command_t    c;
    int unsigned r;
    int unsigned ins;
    int unsigned idx;
    c.data_value = pick_data();
    c.prio = pick_prio();
    if ($urandom_range(0, 1) == 1 && shadow.depth_used > 0)
      c.position = POS_W'($urandom_range(0, shadow.depth_used - 1));
    else
      c.position = POS_W'($urandom_range(0, 15));
    ins = (shadow.depth_used < 4) ? 60 : 35;
    r = $urandom_range(0, 99);
    if (r < ins) begin
      c.func = FN_INSERT;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 15) c.func = FN_DEL_PRIO;
      else if (r < 35) c.func = FN_DEL_FIRST;
      else if (r < 55) c.func = FN_DEL_MATCH;
      else if (r < 60) c.func = FN_CLEAR;
      else if (r < 95) c.func = FN_READ;
      else c.func = $urandom_range(0, 1) ? FN_SPARE_A : FN_SPARE_B;
      // match on a whole queued entry most of the time
      if (c.func == FN_DEL_MATCH && shadow.depth_used > 0 && $urandom_range(0, 2) != 0) begin
        idx = $urandom_range(0, shadow.depth_used - 1);
        c.data_value = shadow.slot_data[idx];
        c.prio = shadow.slot_prio[idx];
      end
    end
    return c;
  endfunction

  // Offer one command beat and hold it until the block takes it
  task automatic send(command_t c);
    int gap;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.func <= c.func;
    req.data_value <= c.data_value;
    req.prio <= c.prio;
    req.position <= c.position;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    shadow.take_command(c);
  endtask

  // Result side: check accepted beats, stall at random, honor hold-off requests
  initial begin
    int       hold_left;
    int       run_left;
    int       stall_left;
    int       asks_seen;
    outcome_t got;
    hold_left = 0;
    run_left = 0;
    stall_left = 0;
    asks_seen = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready) begin
        got.status = status_t'(rsp.status);
        got.removed_count = rsp.removed_count;
        got.entry_count = rsp.entry_count;
        got.read_data = rsp.read_data;
        got.read_prio = rsp.read_prio;
        shadow.match_result(got);
      end
      if (hold_off_asks != asks_seen) begin
        asks_seen = hold_off_asks;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else if (calm) begin
        rsp.ready <= 1'b1;
      end else begin
        if (stall_left == 0 && run_left == 0) begin
          stall_left = idle_len();
          run_left = $urandom_range(1, 12);
        end
        if (stall_left > 0) begin
          stall_left--;
          rsp.ready <= 1'b0;
        end else begin
          run_left--;
          rsp.ready <= 1'b1;
        end
      end
    end
  end

  // Stimulus: directed corner cases, then random sequences, then drain
  initial begin
    command_t    c;
    int          sent;
    int unsigned sel;
    int unsigned n;
    int          k;
    logic signed [DATA_W-1:0] d;
    logic signed [PRIO_W-1:0] p;
    bit          mid_hold_done;
    rst <= 1'b1;
    calm <= 1'b0;
    hold_off_asks <= 0;
    req.valid <= 1'b0;
    req.func <= FN_INSERT;
    req.data_value <= '0;
    req.prio <= '0;
    req.position <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty queue: every delete, clear and read command and the spare codes
    send(command(FN_DEL_PRIO, 32'sd0, 16'sd0, 4'd0));
    send(command(FN_DEL_FIRST, 32'sd0, 16'sd0, 4'd0));
    send(command(FN_DEL_MATCH, 32'sd0, 16'sd0, 4'd0));
    send(command(FN_CLEAR, 32'sd0, 16'sd0, 4'd0));
    send(command(FN_READ, 32'sd0, 16'sd0, 4'd0));
    send(command(FN_SPARE_A, 32'sh7fffffff, 16'sh7fff, 4'd15));
    send(command(FN_SPARE_B, -32'sd1, -16'sd1, 4'd15));
    // extremes and equal priorities kept in arrival order
    send(command(FN_INSERT, 32'sh7fffffff, 16'sh7fff, 4'd15));
    send(command(FN_INSERT, 32'sh80000000, 16'sh8000, 4'd0));
    send(command(FN_INSERT, 32'sd0, 16'sd0, 4'd0));
    send(command(FN_INSERT, -32'sd1, 16'sd0, 4'd0));
    send(command(FN_INSERT, 32'sd5, 16'sd0, 4'd0));
    send(command(FN_INSERT, 32'sd1, -16'sd1, 4'd0));
    for (k = 0; k < 6; k++) send(command(FN_READ, 32'sd0, 16'sd0, k[POS_W-1:0]));
    send(command(FN_READ, 32'sd0, 16'sd0, 4'd6));
    send(command(FN_READ, 32'sd0, 16'sd0, 4'd15));
    send(command(FN_SPARE_A, 32'sd0, 16'sd0, 4'd0));
    send(command(FN_DEL_MATCH, 32'sd7, 16'sd0, 4'd0));
    send(command(FN_DEL_FIRST, 32'sd0, 16'sd0, 4'd0));
    send(command(FN_DEL_MATCH, -32'sd1, 16'sd0, 4'd0));
    send(command(FN_DEL_PRIO, 32'sd0, 16'sh7fff, 4'd0));
    send(command(FN_CLEAR, 32'sd0, 16'sd0, 4'd0));

    // random part opens with a long result-side hold-off
    hold_off_asks <= hold_off_asks + 1;
    sent = 0;
    mid_hold_done = 0;
    sel = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 149) == 0) calm <= ~calm;
      if (!mid_hold_done && sent >= RANDOM_ITEMS / 2) begin
        mid_hold_done = 1;
        hold_off_asks <= hold_off_asks + 1;
      end
      if (sent == 0) sel = 0;
      else sel = $urandom_range(0, 99);
      if (sel < 6) begin
        // fill to the brim and push past it
        n = QUEUE_DEPTH - shadow.depth_used + $urandom_range(1, 3);
        repeat (n) begin
          send(command(FN_INSERT, pick_data(), pick_prio(), POS_W'($urandom_range(0, 15))));
          sent++;
        end
      end else if (sel < 14) begin
        // run of identical entries, then remove them together
        k = $urandom_range(2, 6);
        d = pick_data();
        p = pick_prio();
        repeat (k) begin
          send(command(FN_INSERT, d, p, POS_W'($urandom_range(0, 15))));
          sent++;
        end
        if ($urandom_range(0, 1) == 1)
          send(command(FN_DEL_MATCH, d, p, POS_W'($urandom_range(0, 15))));
        else
          send(command(FN_DEL_PRIO, d, p, POS_W'($urandom_range(0, 15))));
        sent++;
      end else begin
        c = random_command();
        send(c);
        if (c.func <= FN_READ) sent++;
      end
    end
    req.valid <= 1'b0;
    calm <= 1'b0;

    // drain the owed outcomes, then watch for stray beats
    while (shadow.owed_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("summary: %0d commands taken, %0d results checked, largest removal %0d",
             shadow.taken, shadow.matched, shadow.peak_removed);
    $display("summary: %0d full drops, %0d not-found, %0d empty-queue outcomes",
             shadow.full_drops, shadow.misses, shadow.empties);
    if (shadow.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
